FILE: hdl/frt_pkg.sv
package frt_pkg;

	// default size of the event table
	localparam int MAX_EVENTS_DEF = 16;

	// field widths
	localparam int FRAME_W   = 24;
	localparam int SPEED_W   = 16;
	localparam int MS_W      = 16;
	localparam int CMD_W     = 3;
	localparam int MODE_W    = 2;
	localparam int IDX_OUT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	// arithmetic widths: speed * elapsed, position + advance, divider operands
	localparam int PROD_W    = SPEED_W + MS_W;
	localparam int TRI_W     = PROD_W + 2;
	localparam int ADV_SHIFT = 5;
	localparam int SUM_W     = 30;
	localparam int DIV_NUM_W = SUM_W;
	localparam int DIV_DEN_W = FRAME_W;

	// advance = floor(floor(3 * speed * elapsed / 32) / 5)
	// the divide by 5 is a reciprocal multiply, exact for operands below 2^34
	localparam int SCALE_W      = TRI_W - ADV_SHIFT;
	localparam int RECIP_W      = 32;
	localparam int RECIP_SHIFT  = 34;
	localparam int RECIP_PROD_W = SCALE_W + RECIP_W;
	localparam int ADV_W        = RECIP_PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] DIV5_RECIP = 32'hCCCCCCCD;

	// commands
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PLAY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd5;

	// play modes
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;

	// result kinds
	localparam logic KIND_EVENT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE = 2'd3;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SCALE,
		S_DIV5,
		S_ADD,
		S_CMP,
		S_MOD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_STATUS
	} fsm_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/frt_ram.sv
module frt_ram #(
	parameter int WIDTH = frt_pkg::FRAME_W,
	parameter int DEPTH = frt_pkg::MAX_EVENTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hdl/frt_div.sv
module frt_div #(
	parameter int NUM_W = frt_pkg::DIV_NUM_W,
	parameter int DEN_W = frt_pkg::DIV_DEN_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [DEN_W-1:0]  rem,
	output frt_pkg::div_stat_t stat
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    part;
	logic [DEN_W:0]    diff;
	logic              ge;

	// one restoring step: bring down the next numerator bit, subtract if it fits
	always_comb begin
		part = {rem_q, num_q[NUM_W-1]};
		diff = part - {1'b0, den_q};
		ge   = (part >= {1'b0, den_q});
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out, quotient bits shift in behind it
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hdl/frame_timer_with_compare_events_core.sv
// one item at a time; the input is ready again once its status result is in the result register
// a tick with a nonzero max frame multiplies, scales, divides by 5, adds and compares, runs the
// wrap modulo on the divider when the frame wraps, then scans the table if events are enabled;
// begin animation scans the table; each item ends with its status; results go out through one
// register that output stalls hold; reset clears position, mode, done flags, event count, state,
// output valid and configuration; event table contents are left as they are, never read unwritten
module frame_timer_with_compare_events_core #(
	parameter int MAX_EVENTS = frt_pkg::MAX_EVENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// elapsed_ms[15:0], new_event_frame[39:16], new_event_unconditional[40], zero pad
	input  logic [frt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// command[2:0]
	input  logic [frt_pkg::CMD_W-1:0]        s_axis_tuser,
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// fired_index[3:0], current_frame[27:4], play_mode[29:28], done_now[30], done_once[31]
	output logic [frt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// kind[0]
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frt_pkg::FRAME_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(MAX_EVENTS + 1);
	localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

	// configuration registers
	logic [frt_pkg::FRAME_W-1:0] max_q;
	logic                        loop_q;
	logic [frt_pkg::SPEED_W-1:0] speed_q;
	logic                        evt_en_q;

	// playback state
	frt_pkg::fsm_t               state_q, state_d;
	logic [frt_pkg::FRAME_W-1:0] position_q;
	logic [frt_pkg::MODE_W-1:0]  mode_q;
	logic                        fin_q;
	logic                        fin_once_q;
	logic [CNT_W-1:0]            count_q;
	logic [MAX_EVENTS-1:0]       fired_q;
	logic [MAX_EVENTS-1:0]       forced_q;

	// item working registers
	logic [frt_pkg::CMD_W-1:0]   cmd_q;
	logic [frt_pkg::MS_W-1:0]    elapsed_q;
	logic [frt_pkg::PROD_W-1:0]  prod_q;
	logic [frt_pkg::SCALE_W-1:0] scale_q;
	logic [frt_pkg::ADV_W-1:0]   adv_q;
	logic [frt_pkg::SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        loop_clr_q;

	// result register
	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [frt_pkg::IDX_OUT_W-1:0] out_idx_q;
	logic [frt_pkg::FRAME_W-1:0]   out_frame_q;
	logic [frt_pkg::MODE_W-1:0]    out_mode_q;
	logic                          out_fin_q;
	logic                          out_fin_once_q;
	logic                          out_last_q;

	// unpacked input fields
	logic [frt_pkg::CMD_W-1:0]   in_cmd;
	logic [frt_pkg::MS_W-1:0]    in_elapsed;
	logic [frt_pkg::FRAME_W-1:0] in_frame;
	logic                        in_uncond;

	// control
	logic                          in_acc;
	logic                          out_free;
	logic [IDX_W-1:0]              slot;
	logic [IDX_W-1:0]              cidx;
	logic                          room;
	logic                          fire;
	logic                          sum_ge;
	logic                          wrap;
	logic                          hit;
	logic                          tick_fin;
	logic                          load_evt;
	logic                          load_stat;
	logic                          ram_we;
	logic [frt_pkg::TRI_W-1:0]     tri_prod;
	logic [frt_pkg::RECIP_PROD_W-1:0] recip_prod;
	logic [frt_pkg::FRAME_W-1:0]   ram_rd;

	// divider interface
	logic                            div_start;
	logic [frt_pkg::DIV_NUM_W-1:0]   div_num;
	logic [frt_pkg::DIV_DEN_W-1:0]   div_den;
	logic [frt_pkg::DIV_DEN_W-1:0]   div_rem;
	frt_pkg::div_stat_t              div_stat;

	assign in_cmd     = s_axis_tuser;
	assign in_elapsed = s_axis_tdata[15:0];
	assign in_frame   = s_axis_tdata[39:16];
	assign in_uncond  = s_axis_tdata[40];

	// restoring divider for the wrap modulo
	frt_div #(
		.NUM_W(frt_pkg::DIV_NUM_W),
		.DEN_W(frt_pkg::DIV_DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.rem   (div_rem),
		.stat  (div_stat)
	);

	// event frame table
	frt_ram #(
		.WIDTH(frt_pkg::FRAME_W),
		.DEPTH(MAX_EVENTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(cidx),
		.wr_data(in_frame),
		.rd_addr(slot),
		.rd_data(ram_rd)
	);

	// shared condition terms
	always_comb begin
		in_acc   = s_axis_tvalid && s_axis_tready;
		out_free = !out_valid_q || m_axis_tready;
		slot     = cnt_q[IDX_W-1:0];
		cidx     = count_q[IDX_W-1:0];
		room     = (count_q < CNT_W'(MAX_EVENTS));
		if (cmd_q == frt_pkg::CMD_BEGIN) begin
			fire = !fired_q[slot] && forced_q[slot];
		end else begin
			fire = !fired_q[slot] && (ram_rd <= position_q);
		end
		tri_prod   = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
		recip_prod = frt_pkg::RECIP_PROD_W'(scale_q) *
			frt_pkg::RECIP_PROD_W'(frt_pkg::DIV5_RECIP);
		sum_ge   = (sum_q >= frt_pkg::SUM_W'(max_q));
		wrap     = sum_ge && loop_q && (mode_q == frt_pkg::MODE_PLAY);
		hit      = (state_q == frt_pkg::S_MOD) || sum_ge;
		tick_fin = fin_q || hit;
		ram_we   = (state_q == frt_pkg::S_IDLE) && in_acc &&
			(in_cmd == frt_pkg::CMD_ADD) && room;
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = sum_q;
		div_den   = max_q;
		load_evt  = 1'b0;
		load_stat = 1'b0;
		case (state_q)
			frt_pkg::S_IDLE: begin
				if (in_acc) begin
					if (in_cmd == frt_pkg::CMD_TICK) begin
						state_d = (max_q != '0) ? frt_pkg::S_MUL : frt_pkg::S_STATUS;
					end else if (in_cmd == frt_pkg::CMD_BEGIN) begin
						state_d = frt_pkg::S_SCAN_RD;
					end else begin
						state_d = frt_pkg::S_STATUS;
					end
				end
			end
			frt_pkg::S_MUL: begin
				state_d = frt_pkg::S_SCALE;
			end
			frt_pkg::S_SCALE: begin
				state_d = frt_pkg::S_DIV5;
			end
			frt_pkg::S_DIV5: begin
				state_d = frt_pkg::S_ADD;
			end
			frt_pkg::S_ADD: begin
				state_d = frt_pkg::S_CMP;
			end
			frt_pkg::S_CMP: begin
				if (wrap) begin
					div_start = 1'b1;
					state_d   = frt_pkg::S_MOD;
				end else begin
					state_d = evt_en_q ? frt_pkg::S_SCAN_RD : frt_pkg::S_STATUS;
				end
			end
			frt_pkg::S_MOD: begin
				if (div_stat.done) begin
					state_d = evt_en_q ? frt_pkg::S_SCAN_RD : frt_pkg::S_STATUS;
				end
			end
			frt_pkg::S_SCAN_RD: begin
				state_d = (cnt_q == count_q) ? frt_pkg::S_STATUS : frt_pkg::S_SCAN_CHK;
			end
			frt_pkg::S_SCAN_CHK: begin
				if (!fire) begin
					state_d = frt_pkg::S_SCAN_RD;
				end else if (out_free) begin
					load_evt = 1'b1;
					state_d  = frt_pkg::S_SCAN_RD;
				end
			end
			frt_pkg::S_STATUS: begin
				if (out_free) begin
					load_stat = 1'b1;
					state_d   = frt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = frt_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= '0;
			loop_q   <= 1'b0;
			speed_q  <= frt_pkg::SPEED_RESET;
			evt_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				frt_pkg::REG_MAX_FRAME:    max_q    <= cfg_data;
				frt_pkg::REG_LOOP_ENABLE:  loop_q   <= cfg_data[0];
				frt_pkg::REG_SPEED:        speed_q  <= cfg_data[frt_pkg::SPEED_W-1:0];
				frt_pkg::REG_EVENT_ENABLE: evt_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// playback state: commands, frame update, end-of-item table release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			mode_q     <= frt_pkg::MODE_STOP;
			fin_q      <= 1'b0;
			fin_once_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if ((state_q == frt_pkg::S_IDLE) && in_acc) begin
				case (in_cmd)
					frt_pkg::CMD_TICK: begin
						if (max_q == '0) begin
							fin_q <= fin_q && !loop_q;
						end
					end
					frt_pkg::CMD_PLAY: begin
						if (max_q != '0) begin
							mode_q     <= frt_pkg::MODE_PLAY;
							fin_q      <= 1'b0;
							fin_once_q <= 1'b0;
						end
					end
					frt_pkg::CMD_PAUSE: begin
						mode_q <= frt_pkg::MODE_PAUSE;
					end
					frt_pkg::CMD_STOP: begin
						position_q <= '0;
						mode_q     <= frt_pkg::MODE_STOP;
						fin_q      <= 1'b0;
						fin_once_q <= 1'b0;
						count_q    <= '0;
					end
					frt_pkg::CMD_ADD: begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					frt_pkg::CMD_BEGIN: begin
						position_q <= '0;
						mode_q     <= frt_pkg::MODE_STOP;
						fin_q      <= 1'b0;
						fin_once_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			// frame settles: clamp or plain advance here, wrap after the modulo
			if ((state_q == frt_pkg::S_CMP) && !wrap) begin
				position_q <= sum_ge ? max_q : sum_q[frt_pkg::FRAME_W-1:0];
			end
			if ((state_q == frt_pkg::S_MOD) && div_stat.done) begin
				position_q <= div_rem;
			end
			if (((state_q == frt_pkg::S_CMP) && !wrap) ||
				((state_q == frt_pkg::S_MOD) && div_stat.done)) begin
				fin_q      <= tick_fin && !loop_q;
				fin_once_q <= fin_once_q || tick_fin;
			end
			// begin animation empties the table once its scan is over
			if (load_stat && (cmd_q == frt_pkg::CMD_BEGIN)) begin
				count_q <= '0;
			end
		end
	end

	// item datapath and event marks
	always_ff @(posedge clk) begin
		if ((state_q == frt_pkg::S_IDLE) && in_acc) begin
			cmd_q      <= in_cmd;
			elapsed_q  <= in_elapsed;
			cnt_q      <= '0;
			loop_clr_q <= (in_cmd == frt_pkg::CMD_TICK) && (max_q == '0) && fin_q && loop_q;
		end
		if (ram_we) begin
			forced_q[cidx] <= in_uncond;
			fired_q[cidx]  <= 1'b0;
		end
		if (state_q == frt_pkg::S_MUL) begin
			prod_q <= speed_q * elapsed_q;
		end
		// times 3, then divide by 32
		if (state_q == frt_pkg::S_SCALE) begin
			scale_q <= tri_prod[frt_pkg::TRI_W-1:frt_pkg::ADV_SHIFT];
		end
		// divide by 5 through the reciprocal
		if (state_q == frt_pkg::S_DIV5) begin
			adv_q <= recip_prod[frt_pkg::RECIP_PROD_W-1:frt_pkg::RECIP_SHIFT];
		end
		if (state_q == frt_pkg::S_ADD) begin
			if (mode_q == frt_pkg::MODE_PLAY) begin
				sum_q <= frt_pkg::SUM_W'(position_q) + frt_pkg::SUM_W'(adv_q);
			end else begin
				sum_q <= frt_pkg::SUM_W'(position_q);
			end
		end
		if (((state_q == frt_pkg::S_CMP) && !wrap) ||
			((state_q == frt_pkg::S_MOD) && div_stat.done)) begin
			loop_clr_q <= tick_fin && loop_q;
		end
		// scan step
		if ((state_q == frt_pkg::S_SCAN_CHK) && (!fire || out_free)) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (load_evt) begin
			fired_q[slot] <= 1'b1;
		end
		// a looped finish rearms every event
		if (load_stat && loop_clr_q) begin
			fired_q <= '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_evt || load_stat) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_evt || load_stat) begin
			out_kind_q     <= load_stat ? frt_pkg::KIND_STATUS : frt_pkg::KIND_EVENT;
			out_idx_q      <= load_stat ? '0 : frt_pkg::IDX_OUT_W'(slot);
			out_last_q     <= load_stat;
			out_frame_q    <= position_q;
			out_mode_q     <= mode_q;
			out_fin_q      <= fin_q;
			out_fin_once_q <= fin_once_q;
		end
	end

	// ports
	assign s_axis_tready = (state_q == frt_pkg::S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_fin_once_q, out_fin_q, out_mode_q, out_frame_q, out_idx_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule
